// File: rtl/obn_pkg.sv
// ----------------------------------------------------------------------------
// obn_pkg - shared types and constants for the orthonormal basis block
// Q16.16 word and unit-vector types, datapath widths and stage latencies.
// ----------------------------------------------------------------------------
`default_nettype none

package obn_pkg;

  localparam int WORD_W = 32;               // input / ortho_b word
  localparam int FRAC_W = 16;               // fraction bits
  localparam int UNIT_W = FRAC_W + 2;       // unit component, |u| <= 1.0
  localparam int SUM_W  = 2 * WORD_W;       // sum of three squares
  localparam int ROOT_W = WORD_W;           // integer square root
  localparam int LEN_W  = ROOT_W + 1;       // rounded length
  localparam int QUO_W  = FRAC_W + 1;       // unit magnitude quotient
  localparam int DIV_W  = WORD_W + FRAC_W + 1;
  localparam int PROD_W = UNIT_W + WORD_W;  // unit x word product
  localparam int DIF_W  = PROD_W + 1;       // difference of two products

  // mag, square, sum, ROOT_W root steps, length, QUO_W divide steps, round
  localparam int NORM_LAT  = 3 + ROOT_W + 1 + QUO_W + 1;
  localparam int CROSS_LAT = 3;
  localparam int TOTAL_LAT = 2 * NORM_LAT + 2 * CROSS_LAT + 1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef word_t [2:0] wvec_t;
  typedef unit_t [2:0] uvec_t;

  localparam logic signed [DIF_W-1:0]  RND_BIAS = DIF_W'(1) << (FRAC_W - 1);
  localparam logic signed [WORD_W-1:0] W_MAX    = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] W_MIN    = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

`default_nettype wire

// File: rtl/obn_norm.sv
// ----------------------------------------------------------------------------
// obn_norm - pipelined 3-vector normaliser
// Sum of squares, bit-per-stage square root rounded to nearest, then
// bit-per-stage division of each magnitude by the length, ties away from 0.
// ----------------------------------------------------------------------------
`default_nettype none

module obn_norm (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  obn_pkg::wvec_t v,
  output logic          out_valid,
  output obn_pkg::uvec_t u
);
  import obn_pkg::*;

  // front end
  logic              vld1, vld2;
  logic [WORD_W-1:0] mag1 [3];
  logic [WORD_W-1:0] mag2 [3];
  logic [SUM_W-1:0]  sq2  [3];
  logic [2:0]        neg1, neg2;
  logic              zero1, zero2;

  // root steps: element 0 is the sum register
  logic              sq_vld  [ROOT_W+1];
  logic [SUM_W-1:0]  sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];
  logic [WORD_W-1:0] sq_mag  [ROOT_W+1][3];
  logic [2:0]        sq_neg  [ROOT_W+1];
  logic              sq_zero [ROOT_W+1];
  logic [SUM_W-1:0]  sq_trial [ROOT_W];

  // divide steps: element 0 is the length register
  logic              dv_vld  [QUO_W+1];
  logic [DIV_W-1:0]  dv_rem  [QUO_W+1][3];
  logic [QUO_W-1:0]  dv_q    [QUO_W+1][3];
  logic [LEN_W-1:0]  dv_len  [QUO_W+1];
  logic [2:0]        dv_neg  [QUO_W+1];
  logic              dv_zero [QUO_W+1];
  logic [DIV_W-1:0]  dv_trial [QUO_W];

  logic [LEN_W-1:0]  len_next;
  logic [LEN_W:0]    twice_rem [3];
  logic [QUO_W-1:0]  q_rnd [3];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      for (int k = 0; k <= ROOT_W; k++) sq_vld[k] <= 1'b0;
      for (int k = 0; k <= QUO_W; k++) dv_vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      vld2      <= vld1;
      sq_vld[0] <= vld2;
      for (int k = 0; k < ROOT_W; k++) sq_vld[k+1] <= sq_vld[k];
      dv_vld[0] <= sq_vld[ROOT_W];
      for (int k = 0; k < QUO_W; k++) dv_vld[k+1] <= dv_vld[k];
      out_valid <= dv_vld[QUO_W];
    end
  end

  // magnitudes, squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= v[i][WORD_W-1] ? (~v[i] + WORD_W'(1)) : v[i];
      neg1[i] <= v[i][WORD_W-1];
      mag2[i] <= mag1[i];
      sq2[i]  <= SUM_W'(mag1[i]) * SUM_W'(mag1[i]);
    end
    zero1 <= (v[0] == '0) && (v[1] == '0) && (v[2] == '0);
    neg2  <= neg1;
    zero2 <= zero1;
  end

  // one root bit per step: trial = 2*root*2^b + 2^(2b)
  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      sq_trial[k] = (SUM_W'(sq_root[k]) << (ROOT_W - k))
                  | (SUM_W'(1) << (2 * (ROOT_W - 1 - k)));
    end
  end

  // sum register, then the root steps
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq_mag[0][i] <= mag2[i];
    sq_rem[0]  <= sq2[0] + sq2[1] + sq2[2];
    sq_root[0] <= '0;
    sq_neg[0]  <= neg2;
    sq_zero[0] <= zero2;
    for (int k = 0; k < ROOT_W; k++) begin
      if (sq_rem[k] >= sq_trial[k]) begin
        sq_rem[k+1]  <= sq_rem[k] - sq_trial[k];
        sq_root[k+1] <= sq_root[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
      end else begin
        sq_rem[k+1]  <= sq_rem[k];
        sq_root[k+1] <= sq_root[k];
      end
      for (int i = 0; i < 3; i++) sq_mag[k+1][i] <= sq_mag[k][i];
      sq_neg[k+1]  <= sq_neg[k];
      sq_zero[k+1] <= sq_zero[k];
    end
  end

  // round root to nearest: remainder above root means next integer
  always_comb begin
    len_next = LEN_W'(sq_root[ROOT_W])
             + LEN_W'(sq_rem[ROOT_W] > SUM_W'(sq_root[ROOT_W]));
  end

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      dv_trial[k] = DIV_W'(dv_len[k]) << (QUO_W - 1 - k);
    end
  end

  // length register, then one quotient bit per step, all three lanes
  always_ff @(posedge clk) begin
    dv_len[0]  <= len_next;
    dv_neg[0]  <= sq_neg[ROOT_W];
    dv_zero[0] <= sq_zero[ROOT_W];
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= DIV_W'(sq_mag[ROOT_W][i]) << FRAC_W;
      dv_q[0][i]   <= '0;
    end
    for (int k = 0; k < QUO_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[k][i] >= dv_trial[k]) begin
          dv_rem[k+1][i] <= dv_rem[k][i] - dv_trial[k];
          dv_q[k+1][i]   <= dv_q[k][i] | (QUO_W'(1) << (QUO_W - 1 - k));
        end else begin
          dv_rem[k+1][i] <= dv_rem[k][i];
          dv_q[k+1][i]   <= dv_q[k][i];
        end
      end
      dv_len[k+1]  <= dv_len[k];
      dv_neg[k+1]  <= dv_neg[k];
      dv_zero[k+1] <= dv_zero[k];
    end
  end

  // round half away from zero on the magnitude, then restore sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      twice_rem[i] = {dv_rem[QUO_W][i][LEN_W-1:0], 1'b0};
      q_rnd[i]     = dv_q[QUO_W][i]
                   + QUO_W'(twice_rem[i] >= {1'b0, dv_len[QUO_W]});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[QUO_W]) begin
        u[i] <= '0;
      end else if (dv_neg[QUO_W][i]) begin
        u[i] <= -$signed({1'b0, q_rnd[i]});
      end else begin
        u[i] <= $signed({1'b0, q_rnd[i]});
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/obn_cross.sv
// ----------------------------------------------------------------------------
// obn_cross - pipelined fixed-point cross product
// Unit vector p times word vector q, rescaled by 2^-16 round half up,
// saturated to the word range. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module obn_cross (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  obn_pkg::uvec_t p,
  input  obn_pkg::wvec_t q,
  output logic           out_valid,
  output obn_pkg::wvec_t o
);
  import obn_pkg::*;

  logic                     vld1, vld2;
  logic signed [PROD_W-1:0] pr [6];
  logic signed [DIF_W-1:0]  df [3];
  logic signed [DIF_W-1:0]  sh [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    pr[0] <= $signed(p[1]) * $signed(q[2]);
    pr[1] <= $signed(p[2]) * $signed(q[1]);
    pr[2] <= $signed(p[2]) * $signed(q[0]);
    pr[3] <= $signed(p[0]) * $signed(q[2]);
    pr[4] <= $signed(p[0]) * $signed(q[1]);
    pr[5] <= $signed(p[1]) * $signed(q[0]);
    for (int i = 0; i < 3; i++) begin
      df[i] <= DIF_W'(pr[2*i]) - DIF_W'(pr[2*i+1]) + RND_BIAS;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) sh[i] = df[i] >>> FRAC_W;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (sh[i] > DIF_W'(W_MAX)) begin
        o[i] <= W_MAX;
      end else if (sh[i] < DIF_W'(W_MIN)) begin
        o[i] <= W_MIN;
      end else begin
        o[i] <= sh[i][WORD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/orthonormal_basis_from_two_vectors.sv
// ----------------------------------------------------------------------------
// orthonormal_basis_from_two_vectors - orthonormal basis by cross product
// Path from start to done: two normalisers, two cross products and the
//   output register.
// Throughput: one vector pair per cycle; the pipeline never stalls, busy only
//   shows reset, and the receiver takes each beat in its done cycle.
// Reset: synchronous rst clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module orthonormal_basis_from_two_vectors (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           a_x,
  input  logic signed [31:0]           a_y,
  input  logic signed [31:0]           a_z,
  input  logic signed [31:0]           b_x,
  input  logic signed [31:0]           b_y,
  input  logic signed [31:0]           b_z,
  output logic                         done,
  output logic signed [17:0]           unit_a_x,
  output logic signed [17:0]           unit_a_y,
  output logic signed [17:0]           unit_a_z,
  output logic signed [31:0]           ortho_b_x,
  output logic signed [31:0]           ortho_b_y,
  output logic signed [31:0]           ortho_b_z,
  output logic signed [17:0]           normal_c_x,
  output logic signed [17:0]           normal_c_y,
  output logic signed [17:0]           normal_c_z,
  output logic                         degenerate
);
  import obn_pkg::*;

  // Tap depths of the side delay lines, all measured to the output register.
  localparam int B_DLY  = 2 * NORM_LAT + 2 * CROSS_LAT;  // b to final mux
  localparam int UA_DLY = NORM_LAT + 2 * CROSS_LAT;      // unit a to final mux
  localparam int DG_DLY = NORM_LAT + CROSS_LAT;          // flag to final mux

  logic  in_fire;
  wvec_t a_vec, b_vec;

  logic  ua_vld, c_vld, uc_vld, nb_vld;
  uvec_t ua, uc;
  wvec_t c, nb, ua_ext;
  logic  c_zero;

  // Side delay lines: taps at fixed places, one beat per cycle
  wvec_t b_dly  [B_DLY];
  uvec_t ua_dly [UA_DLY];
  logic  dg_dly [DG_DLY];
  uvec_t uc_dly [CROSS_LAT];

  // Nothing ever backs up, so busy is only reset.
  assign busy    = rst;
  assign in_fire = start && !busy;

  assign a_vec = {a_z, a_y, a_x};
  assign b_vec = {b_z, b_y, b_x};

  // unit_a = a / |a|
  obn_norm u_norm_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_fire),
    .v         (a_vec),
    .out_valid (ua_vld),
    .u         (ua)
  );

  // c = unit_a x b, b taken from the delay line in step with unit_a
  obn_cross u_cross_c (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ua_vld),
    .p         (ua),
    .q         (b_dly[NORM_LAT-1]),
    .out_valid (c_vld),
    .o         (c)
  );

  // all-zero cross product: basis cannot be completed
  assign c_zero = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);

  // unit_c = c / |c|; zero c comes out zero
  obn_norm u_norm_c (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld),
    .v         (c),
    .out_valid (uc_vld),
    .u         (uc)
  );

  // unit_a widened to word size for the second cross product
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua_ext[i] = WORD_W'($signed(ua_dly[NORM_LAT+CROSS_LAT-1][i]));
    end
  end

  // new b = unit_c x unit_a
  obn_cross u_cross_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (uc_vld),
    .p         (uc),
    .q         (ua_ext),
    .out_valid (nb_vld),
    .o         (nb)
  );

  // delay lines
  always_ff @(posedge clk) begin
    b_dly[0] <= b_vec;
    for (int k = 1; k < B_DLY; k++) b_dly[k] <= b_dly[k-1];
    ua_dly[0] <= ua;
    for (int k = 1; k < UA_DLY; k++) ua_dly[k] <= ua_dly[k-1];
    dg_dly[0] <= c_zero;
    for (int k = 1; k < DG_DLY; k++) dg_dly[k] <= dg_dly[k-1];
    uc_dly[0] <= uc;
    for (int k = 1; k < CROSS_LAT; k++) uc_dly[k] <= uc_dly[k-1];
  end

  // Output register: on a degenerate beat b passes through and c is zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= nb_vld;
    end
  end

  always_ff @(posedge clk) begin
    unit_a_x   <= ua_dly[UA_DLY-1][0];
    unit_a_y   <= ua_dly[UA_DLY-1][1];
    unit_a_z   <= ua_dly[UA_DLY-1][2];
    degenerate <= dg_dly[DG_DLY-1];
    if (dg_dly[DG_DLY-1]) begin
      ortho_b_x  <= b_dly[B_DLY-1][0];
      ortho_b_y  <= b_dly[B_DLY-1][1];
      ortho_b_z  <= b_dly[B_DLY-1][2];
      normal_c_x <= '0;
      normal_c_y <= '0;
      normal_c_z <= '0;
    end else begin
      ortho_b_x  <= nb[0];
      ortho_b_y  <= nb[1];
      ortho_b_z  <= nb[2];
      normal_c_x <= uc_dly[CROSS_LAT-1][0];
      normal_c_y <= uc_dly[CROSS_LAT-1][1];
      normal_c_z <= uc_dly[CROSS_LAT-1][2];
    end
  end

  // ---- assertions ----
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ##TOTAL_LAT done)
    else $error("accepted beat did not emerge after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_fire, TOTAL_LAT))
    else $error("result beat without a matching accepted beat");

  a_degen_zero_c: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |->
      (normal_c_x == '0 && normal_c_y == '0 && normal_c_z == '0))
    else $error("degenerate beat with non-zero normal");

  a_full_nonzero_c: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |->
      (normal_c_x != '0 || normal_c_y != '0 || normal_c_z != '0))
    else $error("complete basis with zero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (unit_a_x <= 18'sd65536 && unit_a_x >= -18'sd65536 &&
              unit_a_y <= 18'sd65536 && unit_a_y >= -18'sd65536 &&
              unit_a_z <= 18'sd65536 && unit_a_z >= -18'sd65536))
    else $error("unit vector component beyond one");

endmodule

`default_nettype wire
